// ===== rtl/swgt_pkg.sv =====
// Package for the sequence window gap tracker.
// Holds the sequencer state type, the opcode and status codes and parameter defaults.
// No dependencies.
`default_nettype none

package swgt_pkg;

    localparam int unsigned MISSING_DEPTH_DEF = 64;
    localparam int unsigned WINDOW_SPAN_DEF   = 16;

    localparam int unsigned SEQ_W    = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned MCOUNT_W = 7;

    // Opcodes carried on the slave-side tuser
    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NEW       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RECOVERED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ADVANCE   = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MATCH,
        S_GAP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/seq_window_gap_tracker_top.sv =====
// Sequence window gap tracker: highest number, new-packet count and missing table.
// Depends on swgt_pkg (state type, opcode and status codes, defaults).
// Flow: advance and beyond-window items go from S_IDLE straight to S_DONE; other receives
//   sweep the table in S_MATCH (one comparator sweeps the table a slot a cycle), and once
//   more in S_GAP when gaps are stored. A new item is taken only after S_DONE hands the result
//   on; a result still held in the output register keeps the sequencer waiting in S_DONE.
// Reset: synchronous, active low; then a clearing pass over all MISSING_DEPTH slots, s_axis_tready low.
`default_nettype none

module seq_window_gap_tracker_top #(
    parameter int unsigned MISSING_DEPTH = swgt_pkg::MISSING_DEPTH_DEF,
    parameter int unsigned WINDOW_SPAN   = swgt_pkg::WINDOW_SPAN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] seq_no
    input  wire logic [0:0]  s_axis_tuser,   // [0] opcode
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // [0] accepted, [1] gap_lost, [33:2] last_seq,
                                             // [65:34] packet_count, [72:66] missing_count,
                                             // [79:73] zero
    output logic [2:0]       m_axis_tuser    // [2:0] status
);
    import swgt_pkg::*;

    localparam int unsigned IDX_W = (MISSING_DEPTH > 1) ? $clog2(MISSING_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(MISSING_DEPTH + 1);
    localparam int unsigned GAP_W = $clog2(WINDOW_SPAN + 1);
    localparam int unsigned ENT_W = SEQ_W + 1;           // valid flag on top of the entry
    localparam int unsigned VLD_B = SEQ_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MISSING_DEPTH - 1);
    localparam int unsigned PAD_W = 80 - (2 + 2 * SEQ_W + MCOUNT_W);

    // ------------------------------------------------------------------
    // Missing table: one write port, one registered read port.
    // ------------------------------------------------------------------
    logic [ENT_W-1:0] r_mem [MISSING_DEPTH];
    logic [ENT_W-1:0] r_rd_data;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_raddr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_state              r_state,     n_state;
    logic [IDX_W-1:0]    r_idx,       n_idx;       // read (or clear) address issued
    logic                r_rd_vld,    n_rd_vld;    // r_rd_data belongs to r_rd_idx
    logic [IDX_W-1:0]    r_rd_idx;
    logic [SEQ_W-1:0]    r_seq,       n_seq;
    logic [SEQ_W-1:0]    r_highest,   n_highest;
    logic [SEQ_W-1:0]    r_total,     n_total;
    logic [CNT_W-1:0]    r_count,     n_count;
    logic [SEQ_W-1:0]    r_gap_val,   n_gap_val;   // next skipped number to store
    logic [GAP_W-1:0]    r_gap_left,  n_gap_left;  // skipped numbers still to store

    // pending result fields
    logic                r_res_acc,    n_res_acc;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic                r_res_lost,   n_res_lost;

    // output register
    logic                r_out_valid,  n_out_valid;
    logic                r_out_acc,    n_out_acc;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic                r_out_lost,   n_out_lost;
    logic [SEQ_W-1:0]    r_out_last,   n_out_last;
    logic [SEQ_W-1:0]    r_out_total,  n_out_total;
    logic [MCOUNT_W-1:0] r_out_count,  n_out_count;

    logic             w_in_acc;
    logic             w_beyond;
    logic             w_hit;
    logic [GAP_W-1:0] w_gap_cnt;
    logic             w_store;
    logic [GAP_W-1:0] w_left_nx;
    logic [IDX_W-1:0] w_idx_inc;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    // window limit taken in 33 bits so it cannot wrap
    assign w_beyond  = {1'b0, s_axis_tdata} > ({1'b0, r_highest} + (SEQ_W + 1)'(WINDOW_SPAN));
    assign w_hit     = r_rd_data[VLD_B] && (r_rd_data[SEQ_W-1:0] == r_seq);
    assign w_gap_cnt = GAP_W'(r_seq - r_highest - 32'd1);
    assign w_store   = !r_rd_data[VLD_B];
    assign w_left_nx = r_gap_left - GAP_W'(w_store);
    assign w_idx_inc = (r_idx == LAST_IDX) ? '0 : r_idx + IDX_W'(1);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_rd_vld     = 1'b0;
        n_seq        = r_seq;
        n_highest    = r_highest;
        n_total      = r_total;
        n_count      = r_count;
        n_gap_val    = r_gap_val;
        n_gap_left   = r_gap_left;
        n_res_acc    = r_res_acc;
        n_res_status = r_res_status;
        n_res_lost   = r_res_lost;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_acc    = r_out_acc;
        n_out_status = r_out_status;
        n_out_lost   = r_out_lost;
        n_out_last   = r_out_last;
        n_out_total  = r_out_total;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_waddr      = r_rd_idx;
        w_wdata      = '0;
        w_raddr      = r_idx;

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = '0;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            S_IDLE: begin
                if (w_in_acc) begin
                    n_seq = s_axis_tdata;
                    if (s_axis_tuser[0] == OP_ADVANCE) begin
                        n_highest    = r_highest + 32'd1;
                        n_res_acc    = 1'b0;
                        n_res_status = ST_ADVANCE;
                        n_res_lost   = 1'b0;
                        n_state      = S_DONE;
                    end else if (w_beyond) begin
                        n_res_acc    = 1'b0;
                        n_res_status = ST_BEYOND;
                        n_res_lost   = 1'b0;
                        n_state      = S_DONE;
                    end else begin
                        n_idx   = '0;
                        n_state = S_MATCH;
                    end
                end
            end

            S_MATCH: begin
                n_idx    = w_idx_inc;
                n_rd_vld = 1'b1;
                if (r_rd_vld) begin
                    if (w_hit) begin
                        // lowest matching slot: free it
                        w_we         = 1'b1;
                        w_wdata      = '0;
                        n_count      = r_count - CNT_W'(1);
                        n_res_acc    = 1'b1;
                        n_res_status = ST_RECOVERED;
                        n_res_lost   = 1'b0;
                        n_rd_vld     = 1'b0;
                        n_state      = S_DONE;
                    end else if (r_rd_idx == LAST_IDX) begin
                        n_rd_vld = 1'b0;
                        if (r_seq > r_highest) begin
                            if (w_gap_cnt == '0) begin
                                n_highest    = r_seq;
                                n_total      = r_total + 32'd1;
                                n_res_acc    = 1'b1;
                                n_res_status = ST_NEW;
                                n_res_lost   = 1'b0;
                                n_state      = S_DONE;
                            end else begin
                                n_gap_val  = r_highest + 32'd1;
                                n_gap_left = w_gap_cnt;
                                n_idx      = '0;
                                n_state    = S_GAP;
                            end
                        end else begin
                            n_res_acc    = 1'b0;
                            n_res_status = ST_DUPLICATE;
                            n_res_lost   = 1'b0;
                            n_state      = S_DONE;
                        end
                    end
                end
            end

            S_GAP: begin
                n_idx    = w_idx_inc;
                n_rd_vld = 1'b1;
                if (r_rd_vld) begin
                    if (w_store) begin
                        w_we      = 1'b1;
                        w_wdata   = {1'b1, r_gap_val};
                        n_gap_val = r_gap_val + 32'd1;
                        n_count   = r_count + CNT_W'(1);
                    end
                    n_gap_left = w_left_nx;
                    if (w_left_nx == '0 || r_rd_idx == LAST_IDX) begin
                        n_highest    = r_seq;
                        n_total      = r_total + 32'd1;
                        n_res_acc    = 1'b1;
                        n_res_status = ST_NEW;
                        n_res_lost   = (w_left_nx != '0);
                        n_rd_vld     = 1'b0;
                        n_state      = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_acc    = r_res_acc;
                    n_out_status = r_res_status;
                    n_out_lost   = r_res_lost;
                    n_out_last   = r_highest;
                    n_out_total  = r_total;
                    n_out_count  = MCOUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_highest   <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_highest   <= n_highest;
            r_total     <= n_total;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= w_raddr;
        r_seq        <= n_seq;
        r_gap_val    <= n_gap_val;
        r_gap_left   <= n_gap_left;
        r_res_acc    <= n_res_acc;
        r_res_status <= n_res_status;
        r_res_lost   <= n_res_lost;
        r_out_acc    <= n_out_acc;
        r_out_status <= n_out_status;
        r_out_lost   <= n_out_lost;
        r_out_last   <= n_out_last;
        r_out_total  <= n_out_total;
        r_out_count  <= n_out_count;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {PAD_W'(0), r_out_count, r_out_total, r_out_last,
                            r_out_lost, r_out_acc};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MISSING_DEPTH))
        else $error("missing table count above depth");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("item taken during clearing pass");

    a_lost_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_lost) |-> (r_out_status == ST_NEW))
        else $error("gap_lost flagged on a non-new result");

    a_advance_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_ADVANCE) |-> (!r_out_acc && !r_out_lost))
        else $error("advance result carries accepted or gap_lost");

    a_recover_drops_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MATCH && r_rd_vld && w_hit) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("recovered match did not release a slot");

endmodule

`default_nettype wire
